@@ design/i2c_ras_pkg.sv @@
// Package of types, bus status codes and step numbers for the I2C register access sequencer.
package i2c_ras_pkg;

    localparam logic [7:0] BUDGET_RESET = 8'hFF;
    localparam logic [7:0] ST_MASK      = 8'hF8;
    localparam logic [7:0] READ_BIT     = 8'h01;

    localparam logic [1:0] OP_BEGIN_WRITE = 2'd0;
    localparam logic [1:0] OP_BEGIN_READ  = 2'd1;
    localparam logic [1:0] OP_BUS_EVENT   = 2'd2;

    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
    localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    typedef enum logic [2:0] {
        STEP_IDLE      = 3'd0,
        STEP_START     = 3'd1,
        STEP_DEV_ADDR  = 3'd2,
        STEP_REG_ADDR  = 3'd3,
        STEP_DATA      = 3'd4,
        STEP_READ_ADDR = 3'd5,
        STEP_NACK      = 3'd6
    } t_step;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic [7:0] bus_status;
        logic [7:0] received_byte;
    } t_in_item;

    typedef struct packed {
        logic       issue_start;
        logic       issue_stop;
        logic       send_byte_valid;
        logic [7:0] byte_to_send;
        logic       clear_ack;
        logic       transaction_done;
        logic [7:0] read_result;
        logic       retries_exhausted;
        logic [7:0] retries_remaining;
    } t_out_item;

endpackage

@@ design/i2c_ras_if.sv @@
// Channel interfaces for commands and results of the I2C register access sequencer.
interface i2c_ras_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic [7:0] bus_status;
    logic [7:0] received_byte;

    modport source (
        output valid, operation, device_address, register_address, write_value,
               bus_status, received_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, device_address, register_address, write_value,
               bus_status, received_byte,
        output ready
    );
endinterface

interface i2c_ras_out_if;
    logic       valid;
    logic       ready;
    logic       issue_start;
    logic       issue_stop;
    logic       send_byte_valid;
    logic [7:0] byte_to_send;
    logic       clear_ack;
    logic       transaction_done;
    logic [7:0] read_result;
    logic       retries_exhausted;
    logic [7:0] retries_remaining;

    modport source (
        output valid, issue_start, issue_stop, send_byte_valid, byte_to_send, clear_ack,
               transaction_done, read_result, retries_exhausted, retries_remaining,
        input  ready
    );
    modport sink (
        input  valid, issue_start, issue_stop, send_byte_valid, byte_to_send, clear_ack,
               transaction_done, read_result, retries_exhausted, retries_remaining,
        output ready
    );
endinterface

@@ design/i2c_ras_in_stage.sv @@
// Input register that captures one command or status beat.
module i2c_ras_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  i2c_ras_pkg::t_in_item i_item,
    input  logic                  i_advance,
    output logic                  o_ready,
    output logic                  o_valid,
    output i2c_ras_pkg::t_in_item o_item
);
    logic                  r_valid;
    i2c_ras_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

@@ design/i2c_ras_step.sv @@
// Transaction state and next-step logic that turns one beat into engine commands.
module i2c_ras_step (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  i2c_ras_pkg::t_in_item  i_item,
    input  logic [7:0]             i_budget,
    output i2c_ras_pkg::t_out_item o_result
);
    logic               r_is_write, n_is_write;
    i2c_ras_pkg::t_step r_step, n_step;
    logic               r_data_sent, n_data_sent;
    logic [7:0]         r_retry, n_retry;
    logic [7:0]         r_dev, n_dev;
    logic [7:0]         r_reg, n_reg;
    logic [7:0]         r_wval, n_wval;
    logic [7:0]         r_rx, n_rx;
    logic [7:0]         status;
    i2c_ras_pkg::t_out_item res;

    assign status = i_item.bus_status & i2c_ras_pkg::ST_MASK;

    always_comb begin
        n_is_write  = r_is_write;
        n_step      = r_step;
        n_data_sent = r_data_sent;
        n_retry     = r_retry;
        n_dev       = r_dev;
        n_reg       = r_reg;
        n_wval      = r_wval;
        n_rx        = r_rx;
        res         = '0;
        if (i_item.operation == i2c_ras_pkg::OP_BEGIN_WRITE ||
            i_item.operation == i2c_ras_pkg::OP_BEGIN_READ) begin
            n_is_write = (i_item.operation == i2c_ras_pkg::OP_BEGIN_WRITE);
            n_dev      = i_item.device_address;
            n_reg      = i_item.register_address;
            if (i_item.operation == i2c_ras_pkg::OP_BEGIN_WRITE) begin
                n_wval = i_item.write_value;
            end
            n_step          = i2c_ras_pkg::STEP_START;
            n_retry         = i_budget;
            res.issue_start = 1'b1;
        end else if (i_item.operation == i2c_ras_pkg::OP_BUS_EVENT) begin
            case (status)
                i2c_ras_pkg::ST_START: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send    = r_dev;
                    n_step              = i2c_ras_pkg::STEP_DEV_ADDR;
                end
                i2c_ras_pkg::ST_MT_SLA_ACK: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send    = r_reg;
                    n_step              = i2c_ras_pkg::STEP_REG_ADDR;
                    n_data_sent         = 1'b0;
                end
                i2c_ras_pkg::ST_MT_DATA_ACK: begin
                    if (r_data_sent) begin
                        res.issue_stop       = 1'b1;
                        res.transaction_done = 1'b1;
                    end else begin
                        if (r_is_write) begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send    = r_wval;
                            n_data_sent         = 1'b1;
                        end else begin
                            res.issue_start = 1'b1;
                        end
                        n_step = i2c_ras_pkg::STEP_DATA;
                    end
                end
                i2c_ras_pkg::ST_REP_START: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send    = r_dev | i2c_ras_pkg::READ_BIT;
                    n_step              = i2c_ras_pkg::STEP_READ_ADDR;
                end
                i2c_ras_pkg::ST_MR_SLA_ACK: begin
                    res.clear_ack = 1'b1;
                    n_step        = i2c_ras_pkg::STEP_NACK;
                end
                i2c_ras_pkg::ST_MR_DATA_NACK: begin
                    n_rx                 = i_item.received_byte;
                    res.issue_stop       = 1'b1;
                    res.transaction_done = 1'b1;
                end
                default: begin
                    n_retry = r_retry - 8'd1;
                    unique case (r_step)
                        i2c_ras_pkg::STEP_START: res.issue_start = 1'b1;
                        i2c_ras_pkg::STEP_DEV_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send    = r_dev;
                        end
                        i2c_ras_pkg::STEP_REG_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send    = r_reg;
                        end
                        i2c_ras_pkg::STEP_DATA: begin
                            if (r_is_write) begin
                                res.send_byte_valid = 1'b1;
                                res.byte_to_send    = r_wval;
                            end else begin
                                res.issue_start = 1'b1;
                            end
                        end
                        i2c_ras_pkg::STEP_READ_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send    = r_dev | i2c_ras_pkg::READ_BIT;
                        end
                        i2c_ras_pkg::STEP_NACK: res.clear_ack = 1'b1;
                        default: ;
                    endcase
                    if (n_retry == 8'd0) begin
                        res.issue_stop        = 1'b1;
                        res.transaction_done  = 1'b1;
                        res.retries_exhausted = 1'b1;
                    end
                end
            endcase
        end
        res.read_result       = n_rx;
        res.retries_remaining = n_retry;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_write  <= 1'b0;
            r_step      <= i2c_ras_pkg::STEP_IDLE;
            r_data_sent <= 1'b0;
            r_retry     <= 8'd0;
            r_dev       <= 8'd0;
            r_reg       <= 8'd0;
            r_wval      <= 8'd0;
            r_rx        <= 8'd0;
        end else if (i_en) begin
            r_is_write  <= n_is_write;
            r_step      <= n_step;
            r_data_sent <= n_data_sent;
            r_retry     <= n_retry;
            r_dev       <= n_dev;
            r_reg       <= n_reg;
            r_wval      <= n_wval;
            r_rx        <= n_rx;
        end
    end
endmodule

@@ design/i2c_ras_out_stage.sv @@
// Result register that holds one result beat until the receiver takes it.
module i2c_ras_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  i2c_ras_pkg::t_out_item i_result,
    input  logic                   i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output i2c_ras_pkg::t_out_item o_result
);
    logic                   r_valid;
    i2c_ras_pkg::t_out_item r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end
endmodule

@@ design/i2c_register_access_sequencer.sv @@
// Top level of the I2C register access sequencer.
// The input channel carries begin-write and begin-read commands and status
// beats from a byte-level bus engine; each input beat yields exactly one
// result beat on the output channel with the engine commands (start, stop,
// byte to send, NACK), the done and failure flags, the read byte and the
// retry counter. The retry budget is written through i_cfg_we and
// i_cfg_wdata, only while no beat is in flight, a rule the user must keep
// as the block itself does not enforce it; the budget is loaded on every begin.
// A beat is captured in the input register, processed in a single pass of
// next-step logic and written to the result register once that register is
// free. One beat is accepted per cycle through the two-register pipeline
// while the receiver takes every result beat.
// When the receiver stalls, the result register holds its beat, the input
// register holds the next one, and input ready falls once both are full.
// Synchronous reset empties both registers, clears the transaction state
// and sets the retry budget to 255.
module i2c_register_access_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    i2c_ras_in_if.sink    i_in,
    i2c_ras_out_if.source o_out
);
    logic [7:0]             r_retry_budget;
    logic                   in_valid;
    logic                   out_free;
    logic                   advance;
    logic                   out_valid;
    i2c_ras_pkg::t_in_item  in_item;
    i2c_ras_pkg::t_in_item  stage_item;
    i2c_ras_pkg::t_out_item step_result;
    i2c_ras_pkg::t_out_item out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_budget <= i2c_ras_pkg::BUDGET_RESET;
        end else if (i_cfg_we) begin
            r_retry_budget <= i_cfg_wdata;
        end
    end

    assign in_item.operation        = i_in.operation;
    assign in_item.device_address   = i_in.device_address;
    assign in_item.register_address = i_in.register_address;
    assign in_item.write_value      = i_in.write_value;
    assign in_item.bus_status       = i_in.bus_status;
    assign in_item.received_byte    = i_in.received_byte;

    assign advance = in_valid && out_free;

    i2c_ras_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (in_valid),
        .o_item    (stage_item)
    );

    i2c_ras_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (stage_item),
        .i_budget (r_retry_budget),
        .o_result (step_result)
    );

    i2c_ras_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (step_result),
        .i_ready  (o_out.ready),
        .o_free   (out_free),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid             = out_valid;
    assign o_out.issue_start       = out_result.issue_start;
    assign o_out.issue_stop        = out_result.issue_stop;
    assign o_out.send_byte_valid   = out_result.send_byte_valid;
    assign o_out.byte_to_send      = out_result.byte_to_send;
    assign o_out.clear_ack         = out_result.clear_ack;
    assign o_out.transaction_done  = out_result.transaction_done;
    assign o_out.read_result       = out_result.read_result;
    assign o_out.retries_exhausted = out_result.retries_exhausted;
    assign o_out.retries_remaining = out_result.retries_remaining;
endmodule

@@ dv/i2c_register_access_sequencer_test.sv @@
// Self-checking testbench for the I2C register access sequencer: directed rows, then random traffic.
`timescale 1ns / 100ps

module i2c_register_access_sequencer_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
    localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
    localparam logic [7:0] ST_NO_INFO     = 8'hF8;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int N_DIRECTED    = 27;
    localparam int N_PHASES      = 8;
    localparam int PHASE_BEATS   = 190;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        bit                     cfg_write;
        logic [7:0]             cfg_value;
        i2c_ras_pkg::t_in_item  beat;
        bit                     typed;
        i2c_ras_pkg::t_out_item want;
    } t_directed_row;

    localparam i2c_ras_pkg::t_out_item NOT_TYPED = '0;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [7:0] i_cfg_wdata;

    i2c_ras_in_if  in_ch ();
    i2c_ras_out_if out_ch ();

    i2c_register_access_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Shadow state of the sequencer, kept in step with every accepted beat.
    logic [7:0]         seq_budget    = i2c_ras_pkg::BUDGET_RESET;
    logic               seq_is_write  = 1'b0;
    i2c_ras_pkg::t_step seq_step      = i2c_ras_pkg::STEP_IDLE;
    logic               seq_data_sent = 1'b0;
    logic [7:0]         seq_retries   = 8'h00;
    logic [7:0]         seq_dev       = 8'h00;
    logic [7:0]         seq_reg       = 8'h00;
    logic [7:0]         seq_wval      = 8'h00;
    logic [7:0]         seq_rx_store  = 8'h00;

    i2c_ras_pkg::t_out_item expected_results [$];
    int unsigned sender_idle_pct  = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned counted_beats    = 0;
    int unsigned ignored_beats    = 0;
    int unsigned results_checked  = 0;
    int unsigned done_count       = 0;
    int unsigned exhausted_count  = 0;
    int unsigned budget_writes    = 0;
    int unsigned error_count      = 0;
    int unsigned cycle_count      = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{1'b0, 8'h00, '{OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
          1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00}},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_BUS_ERROR | 8'h07, 8'h00},
          1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF}},
        '{1'b0, 8'h00, '{i2c_ras_pkg::OP_BEGIN_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00},
          1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 8'hFF}},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_START | 8'h07, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_SLA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_DATA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_DATA_ACK | 8'h07, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00, '{i2c_ras_pkg::OP_BEGIN_READ, 8'h00, 8'hFF, 8'hAA, 8'h00, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_DATA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_START, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_NO_INFO, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_SLA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MT_DATA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MT_DATA_NACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_REP_START, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_NO_INFO | 8'h07, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MR_SLA_ACK, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_BUS_ERROR, 8'h00},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MR_DATA_NACK, 8'hA5},
          1'b0, NOT_TYPED},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_MR_DATA_NACK | 8'h07, 8'h5A},
          1'b0, NOT_TYPED},
        '{1'b1, 8'h01, '0, 1'b0, NOT_TYPED},
        '{1'b0, 8'h00, '{i2c_ras_pkg::OP_BEGIN_WRITE, 8'h42, 8'h10, 8'h99, 8'h00, 8'h00},
          1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h5A, 1'b0, 8'h01}},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_ARB_LOST, 8'h00},
          1'b1, '{1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 8'h5A, 1'b1, 8'h00}},
        '{1'b1, 8'h00, '0, 1'b0, NOT_TYPED},
        '{1'b0, 8'h00, '{i2c_ras_pkg::OP_BEGIN_READ, 8'h81, 8'h7E, 8'h00, 8'h00, 8'h00},
          1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h5A, 1'b0, 8'h00}},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MR_SLA_NACK, 8'h00},
          1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 8'h5A, 1'b0, 8'hFF}},
        '{1'b0, 8'h00,
          '{i2c_ras_pkg::OP_BUS_EVENT, 8'h00, 8'h00, 8'h00,
            i2c_ras_pkg::ST_START, 8'h00},
          1'b0, NOT_TYPED}
    };

    always #5 i_clk = ~i_clk;

    function automatic i2c_ras_pkg::t_out_item sequence_step(i2c_ras_pkg::t_in_item beat);
        i2c_ras_pkg::t_out_item res;
        logic [7:0]             status;
        res = '0;
        status = beat.bus_status & i2c_ras_pkg::ST_MASK;
        if (beat.operation == i2c_ras_pkg::OP_BEGIN_WRITE ||
            beat.operation == i2c_ras_pkg::OP_BEGIN_READ) begin
            seq_is_write = (beat.operation == i2c_ras_pkg::OP_BEGIN_WRITE);
            seq_dev = beat.device_address;
            seq_reg = beat.register_address;
            if (seq_is_write) begin
                seq_wval = beat.write_value;
            end
            seq_step = i2c_ras_pkg::STEP_START;
            seq_retries = seq_budget;
            res.issue_start = 1'b1;
        end else if (beat.operation == i2c_ras_pkg::OP_BUS_EVENT) begin
            case (status)
                i2c_ras_pkg::ST_START: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send = seq_dev;
                    seq_step = i2c_ras_pkg::STEP_DEV_ADDR;
                end
                i2c_ras_pkg::ST_MT_SLA_ACK: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send = seq_reg;
                    seq_step = i2c_ras_pkg::STEP_REG_ADDR;
                    seq_data_sent = 1'b0;
                end
                i2c_ras_pkg::ST_MT_DATA_ACK: begin
                    if (seq_data_sent) begin
                        res.issue_stop = 1'b1;
                        res.transaction_done = 1'b1;
                    end else begin
                        if (seq_is_write) begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send = seq_wval;
                            seq_data_sent = 1'b1;
                        end else begin
                            res.issue_start = 1'b1;
                        end
                        seq_step = i2c_ras_pkg::STEP_DATA;
                    end
                end
                i2c_ras_pkg::ST_REP_START: begin
                    res.send_byte_valid = 1'b1;
                    res.byte_to_send = seq_dev | i2c_ras_pkg::READ_BIT;
                    seq_step = i2c_ras_pkg::STEP_READ_ADDR;
                end
                i2c_ras_pkg::ST_MR_SLA_ACK: begin
                    res.clear_ack = 1'b1;
                    seq_step = i2c_ras_pkg::STEP_NACK;
                end
                i2c_ras_pkg::ST_MR_DATA_NACK: begin
                    seq_rx_store = beat.received_byte;
                    res.issue_stop = 1'b1;
                    res.transaction_done = 1'b1;
                end
                default: begin
                    seq_retries = seq_retries - 8'd1;
                    case (seq_step)
                        i2c_ras_pkg::STEP_START: res.issue_start = 1'b1;
                        i2c_ras_pkg::STEP_DEV_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send = seq_dev;
                        end
                        i2c_ras_pkg::STEP_REG_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send = seq_reg;
                        end
                        i2c_ras_pkg::STEP_DATA: begin
                            if (seq_is_write) begin
                                res.send_byte_valid = 1'b1;
                                res.byte_to_send = seq_wval;
                            end else begin
                                res.issue_start = 1'b1;
                            end
                        end
                        i2c_ras_pkg::STEP_READ_ADDR: begin
                            res.send_byte_valid = 1'b1;
                            res.byte_to_send = seq_dev | i2c_ras_pkg::READ_BIT;
                        end
                        i2c_ras_pkg::STEP_NACK: res.clear_ack = 1'b1;
                        default: ;
                    endcase
                    if (seq_retries == 8'd0) begin
                        res.issue_stop = 1'b1;
                        res.transaction_done = 1'b1;
                        res.retries_exhausted = 1'b1;
                    end
                end
            endcase
        end
        res.read_result = seq_rx_store;
        res.retries_remaining = seq_retries;
        return res;
    endfunction

    function automatic i2c_ras_pkg::t_in_item random_beat();
        i2c_ras_pkg::t_in_item beat;
        beat.operation = 2'($urandom_range(0, 3));
        beat.device_address = 8'($urandom_range(0, 255));
        beat.register_address = 8'($urandom_range(0, 255));
        beat.write_value = 8'($urandom_range(0, 255));
        beat.bus_status = 8'($urandom_range(0, 255));
        beat.received_byte = 8'($urandom_range(0, 255));
        return beat;
    endfunction

    function automatic i2c_ras_pkg::t_in_item status_beat(logic [7:0] status);
        i2c_ras_pkg::t_in_item beat;
        beat = random_beat();
        beat.operation = i2c_ras_pkg::OP_BUS_EVENT;
        beat.bus_status = status;
        return beat;
    endfunction

    task automatic push_beat(i2c_ras_pkg::t_in_item beat, bit typed = 1'b0,
                             i2c_ras_pkg::t_out_item want = '0);
        i2c_ras_pkg::t_out_item predicted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= beat.operation;
        in_ch.device_address <= beat.device_address;
        in_ch.register_address <= beat.register_address;
        in_ch.write_value <= beat.write_value;
        in_ch.bus_status <= beat.bus_status;
        in_ch.received_byte <= beat.received_byte;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = sequence_step(beat);
        expected_results.push_back(typed ? want : predicted);
        if (beat.operation == OP_UNUSED) begin
            ignored_beats++;
        end else begin
            counted_beats++;
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_budget(logic [7:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seq_budget = value;
        budget_writes++;
    endtask

    // Mostly complete transactions with random content, with retries, aborts and noise mixed in.
    task automatic random_traffic(int unsigned n_beats);
        int unsigned           target;
        int unsigned           pick;
        i2c_ras_pkg::t_in_item beat;
        logic [7:0]            codes [$];
        target = counted_beats + n_beats;
        while (counted_beats < target) begin
            pick = $urandom_range(0, 99);
            beat = random_beat();
            if (pick < 85) begin
                if ($urandom_range(0, 1) == 0) begin
                    beat.operation = i2c_ras_pkg::OP_BEGIN_WRITE;
                    codes = {i2c_ras_pkg::ST_START, i2c_ras_pkg::ST_MT_SLA_ACK,
                             i2c_ras_pkg::ST_MT_DATA_ACK, i2c_ras_pkg::ST_MT_DATA_ACK};
                end else begin
                    beat.operation = i2c_ras_pkg::OP_BEGIN_READ;
                    codes = {i2c_ras_pkg::ST_START, i2c_ras_pkg::ST_MT_SLA_ACK,
                             i2c_ras_pkg::ST_MT_DATA_ACK, i2c_ras_pkg::ST_REP_START,
                             i2c_ras_pkg::ST_MR_SLA_ACK, i2c_ras_pkg::ST_MR_DATA_NACK};
                end
                push_beat(beat);
                foreach (codes[i]) begin
                    if ($urandom_range(0, 99) < 3) begin
                        break;
                    end
                    while ($urandom_range(0, 99) < 8) begin
                        push_beat(status_beat(8'($urandom_range(0, 255))));
                    end
                    push_beat(status_beat(codes[i] | 8'($urandom_range(0, 7))));
                end
            end else if (pick < 95) begin
                push_beat(beat);
            end else begin
                beat.operation = OP_UNUSED;
                push_beat(beat);
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_drained();
            end
        end
    endtask

    task automatic report_failure(string what, logic [7:0] want, logic [7:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("result %0d: %s expected %h, got %h", results_checked, what, want, got);
        end
    endtask

    task automatic check_result(i2c_ras_pkg::t_out_item got);
        i2c_ras_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("result beat arrived with nothing outstanding");
            end
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (want.transaction_done) done_count++;
        if (want.retries_exhausted) exhausted_count++;
        if (got.issue_start !== want.issue_start)
            report_failure("issue_start", 8'(want.issue_start), 8'(got.issue_start));
        if (got.issue_stop !== want.issue_stop)
            report_failure("issue_stop", 8'(want.issue_stop), 8'(got.issue_stop));
        if (got.send_byte_valid !== want.send_byte_valid)
            report_failure("send_byte_valid", 8'(want.send_byte_valid),
                           8'(got.send_byte_valid));
        if (got.byte_to_send !== want.byte_to_send)
            report_failure("byte_to_send", want.byte_to_send, got.byte_to_send);
        if (got.clear_ack !== want.clear_ack)
            report_failure("clear_ack", 8'(want.clear_ack), 8'(got.clear_ack));
        if (got.transaction_done !== want.transaction_done)
            report_failure("transaction_done", 8'(want.transaction_done),
                           8'(got.transaction_done));
        if (got.read_result !== want.read_result)
            report_failure("read_result", want.read_result, got.read_result);
        if (got.retries_exhausted !== want.retries_exhausted)
            report_failure("retries_exhausted", 8'(want.retries_exhausted),
                           8'(got.retries_exhausted));
        if (got.retries_remaining !== want.retries_remaining)
            report_failure("retries_remaining", want.retries_remaining, got.retries_remaining);
    endtask

    always @(posedge i_clk) begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            check_result('{out_ch.issue_start, out_ch.issue_stop, out_ch.send_byte_valid,
                           out_ch.byte_to_send, out_ch.clear_ack, out_ch.transaction_done,
                           out_ch.read_result, out_ch.retries_exhausted,
                           out_ch.retries_remaining});
        end
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("i2c_register_access_sequencer_test: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'h00;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_UNUSED;
        in_ch.device_address = 8'h00;
        in_ch.register_address = 8'h00;
        in_ch.write_value = 8'h00;
        in_ch.bus_status = 8'h00;
        in_ch.received_byte = 8'h00;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_write) begin
                write_budget(directed_rows[i].cfg_value);
            end else begin
                push_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Each phase pairs a retry budget with one pattern of idling on the two channels.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase % 4)
                0: write_budget(phase == 0 ? 8'hFF : 8'h02);
                1: write_budget(8'h01);
                2: write_budget(phase == 2 ? 8'h00 : 8'hFF);
                default: write_budget(8'($urandom_range(1, 255)));
            endcase
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    sender_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            random_traffic(PHASE_BEATS);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("%0d command and status beats sent, %0d ignored beats, %0d results checked",
                 counted_beats, ignored_beats, results_checked);
        $display("%0d transactions finished, %0d abandoned on an empty retry counter, %0d budgets",
                 done_count, exhausted_count, budget_writes);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("i2c_register_access_sequencer_test: clean");
        end else begin
            $display("%0d failures, %0d results outstanding", error_count,
                     expected_results.size());
            $display("i2c_register_access_sequencer_test: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/i2c_ras_pkg.sv
design/i2c_ras_if.sv
design/i2c_ras_in_stage.sv
design/i2c_ras_step.sv
design/i2c_ras_out_stage.sv
design/i2c_register_access_sequencer.sv
dv/i2c_register_access_sequencer_test.sv
